// ----- hdl/gwsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_pkg
// Shared types and field constants for the gated window sum accumulator:
// word layout, datapath widths, lane control and the sequencer states.
// ----------------------------------------------------------------------------
package gwsa_pkg;

	// raw word layout
	localparam int VALUE_LSB = 14;
	localparam int VALUE_W   = 18;
	localparam int GATE_BIT  = 12;
	localparam int PRESC_LSB = 4;
	localparam int PRESC_W   = 7;
	localparam int CHAN_W    = 4;
	localparam int WORD_W    = 32;

	// datapath widths
	localparam int TIME_W    = 64;
	localparam int TPS_W     = 16;
	localparam int IDX_W     = 10;
	localparam int IDX2_W    = IDX_W + 1;
	localparam int SCALE_W   = PRESC_W + 1;
	localparam int INTV_W    = TPS_W + SCALE_W;
	localparam int PROD_W    = IDX2_W + INTV_W;
	localparam int SUM_W     = 38;
	localparam int CNT_OUT_W = 20;
	localparam int TOG_W     = 2;

	// toggles that close one gate-high plus gate-low window
	localparam logic [TOG_W-1:0] TOG_CLOSE = 2'd2;

	// per-item control handed to each channel lane
	typedef struct packed {
		logic en;        // apply this item
		logic clear;     // clear sums before adding
		logic add_high;  // add value into the gate-high sum
		logic add_low;   // add value into the gate-low sum
	} gwsa_lane_ctl_t;

	// item sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PROD,
		ST_SUM,
		ST_DONE
	} gwsa_state_t;

endpackage

`default_nettype wire

// ----- hdl/gwsa_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gwsa_lane
// One channel lane: holds the gate-high and gate-low running sums of its
// channel and reports the sums of the window that is closing.
// ----------------------------------------------------------------------------
module gwsa_lane
	import gwsa_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire gwsa_lane_ctl_t           ctl,
	input  wire logic [WORD_W-1:0]        word,
	output logic signed [SUM_W-1:0]       high_sum,
	output logic signed [SUM_W-1:0]       low_sum
);

	logic [VALUE_W-1:0] value;
	logic [SUM_W-1:0]   value_ext;
	logic [SUM_W-1:0]   high_sum_q;
	logic [SUM_W-1:0]   low_sum_q;
	logic [SUM_W-1:0]   high_base;
	logic [SUM_W-1:0]   low_base;

	// sign-extend the 18-bit sample value
	assign value     = word[VALUE_LSB +: VALUE_W];
	assign value_ext = {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};

	// start from zero when the window closes on this item
	assign high_base = ctl.clear ? '0 : high_sum_q;
	assign low_base  = ctl.clear ? '0 : low_sum_q;

	// accumulate, wrapping at the sum width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_sum_q <= '0;
			low_sum_q  <= '0;
		end else if (ctl.en) begin
			high_sum_q <= ctl.add_high ? high_base + value_ext : high_base;
			low_sum_q  <= ctl.add_low  ? low_base + value_ext  : low_base;
		end
	end

	assign high_sum = $signed(high_sum_q);
	assign low_sum  = $signed(low_sum_q);

endmodule

`default_nettype wire

// ----- hdl/gated_window_sum_accumulator_top.sv -----
// Flow: an accepted item passes the MUL, PROD and SUM states to DONE, which
// loads its result into the output register once that register is free.
// Items: one item at a time; the next is accepted after the serial time chain
// (prescale multiply, index multiply, 64-bit add, then gap check and update).
// Reset: arst_n clears the sequencer, window state, counts, sums and sets
// ticks_per_sample to 1.
`default_nettype none
// ----------------------------------------------------------------------------
// gated_window_sum_accumulator_top
// Unpacks a two-channel sample pair, computes its sample time and gap, and
// sums each channel over gate-high and gate-low samples in two lanes;
// windows close on every second gate toggle and the merge stage reports them.
// ----------------------------------------------------------------------------
module gated_window_sum_accumulator_top
	import gwsa_pkg::*;
#(
	parameter int COUNT_BITS  = 20,
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_wr_en,
	input  wire logic [TPS_W-1:0]         cfg_wr_data,
	// input items
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [WORD_W-1:0] ch0_word,
	input  wire logic signed [WORD_W-1:0] ch1_word,
	input  wire logic [TIME_W-1:0]        packet_stamp,
	input  wire logic [IDX_W-1:0]         sample_index,
	input  wire logic                     first_of_run,
	// result items
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [TIME_W-1:0]             sample_time,
	output logic                          gap_flag,
	output logic [TIME_W-1:0]             gap_ticks,
	output logic                          window_done,
	output logic signed [SUM_W-1:0]       ch0_high_sum,
	output logic signed [SUM_W-1:0]       ch0_low_sum,
	output logic signed [SUM_W-1:0]       ch1_high_sum,
	output logic signed [SUM_W-1:0]       ch1_low_sum,
	output logic [CNT_OUT_W-1:0]          high_count,
	output logic [CNT_OUT_W-1:0]          low_count
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	gwsa_state_t state_q, state_d;

	logic                  load_en;
	logic                  mul_en;
	logic                  prod_en;
	logic                  sum_en;
	logic                  done_fire;

	logic [TPS_W-1:0]      tps_q;
	logic [WORD_W-1:0]     ch0_word_q;
	logic [WORD_W-1:0]     ch1_word_q;
	logic [TIME_W-1:0]     stamp_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  first_q;

	logic [IDX_W-1:0]      idx_clamp;
	logic [IDX2_W-1:0]     idx_eff;
	logic [SCALE_W-1:0]    presc;
	logic [IDX2_W-1:0]     idx_eff_q;
	logic [INTV_W-1:0]     interval_q;
	logic [PROD_W-1:0]     prod_q;
	logic [TIME_W-1:0]     time_q;

	logic                  seen_q;
	logic                  gate_ref_q;
	logic [TOG_W-1:0]      tog_q;
	logic [TIME_W-1:0]     prev_time_q;
	logic [COUNT_BITS-1:0] cnt_high_q;
	logic [COUNT_BITS-1:0] cnt_low_q;

	logic                  gate;
	logic                  ref_eff;
	logic [TOG_W-1:0]      tog_eff;
	logic [TOG_W-1:0]      tog_inc;
	logic                  win_close;
	logic [TIME_W-1:0]     prev_eff;
	logic [TIME_W-1:0]     diff;
	logic                  gap;
	logic [COUNT_BITS-1:0] cnt_high_base;
	logic [COUNT_BITS-1:0] cnt_low_base;
	logic                  add_high;
	logic                  add_low;

	gwsa_lane_ctl_t        lane_ctl;
	logic signed [SUM_W-1:0] l0_high, l0_low, l1_high, l1_low;

	logic                  out_valid_q;
	logic [TIME_W-1:0]     sample_time_q;
	logic                  gap_flag_q;
	logic [TIME_W-1:0]     gap_ticks_q;
	logic                  window_done_q;
	logic [SUM_W-1:0]      ch0_high_q, ch0_low_q, ch1_high_q, ch1_low_q;
	logic [CNT_OUT_W-1:0]  high_count_q, low_count_q;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_PROD;
			ST_PROD: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: stage enables
	always_comb begin
		in_ready  = 1'b0;
		mul_en    = 1'b0;
		prod_en   = 1'b0;
		sum_en    = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_MUL:  mul_en    = 1'b1;
			ST_PROD: prod_en   = 1'b1;
			ST_SUM:  sum_en    = 1'b1;
			ST_DONE: done_fire = !out_valid_q || out_ready;
			default: in_ready  = 1'b0;
		endcase
	end

	assign load_en = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_W'(1);
		end else if (cfg_wr_en) begin
			tps_q <= cfg_wr_data;
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (load_en) begin
			ch0_word_q <= ch0_word;
			ch1_word_q <= ch1_word;
			stamp_q    <= packet_stamp;
			idx_q      <= sample_index;
			first_q    <= first_of_run;
		end
	end

	// clamp the index, double it for equal channel numbers
	assign idx_clamp = (32'(idx_q) > 32'(MAX_SAMPLES - 1)) ? IDX_W'(MAX_SAMPLES - 1) : idx_q;
	assign idx_eff   = (ch0_word_q[CHAN_W-1:0] == ch1_word_q[CHAN_W-1:0])
		? {idx_clamp, 1'b0} : {1'b0, idx_clamp};
	assign presc     = {1'b0, ch0_word_q[PRESC_LSB +: PRESC_W]} + SCALE_W'(1);

	// time chain: interval, index product, absolute time
	always_ff @(posedge clk) begin
		if (mul_en) begin
			interval_q <= INTV_W'(tps_q) * INTV_W'(presc);
			idx_eff_q  <= idx_eff;
		end
		if (prod_en) begin
			prod_q <= PROD_W'(idx_eff_q) * PROD_W'(interval_q);
		end
		if (sum_en) begin
			time_q <= stamp_q + TIME_W'(prod_q);
		end
	end

	// gap check against the previous sample time
	assign gate     = ch0_word_q[GATE_BIT];
	assign prev_eff = seen_q ? prev_time_q : time_q;
	assign diff     = time_q - prev_eff;
	assign gap      = !first_q && (diff > TIME_W'(interval_q));

	// gate toggle tracking; the very first item sets the reference
	assign ref_eff   = seen_q ? gate_ref_q : gate;
	assign tog_eff   = seen_q ? tog_q : '0;
	assign tog_inc   = (gate != ref_eff) ? tog_eff + TOG_W'(1) : tog_eff;
	assign win_close = (tog_inc == TOG_CLOSE);

	// counts after a possible window clear, and saturation gating
	assign cnt_high_base = win_close ? '0 : cnt_high_q;
	assign cnt_low_base  = win_close ? '0 : cnt_low_q;
	assign add_high      = gate && (cnt_high_base != COUNT_MAX);
	assign add_low       = !gate && (cnt_low_base != COUNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			gate_ref_q  <= 1'b0;
			tog_q       <= '0;
			prev_time_q <= '0;
			cnt_high_q  <= '0;
			cnt_low_q   <= '0;
		end else if (done_fire) begin
			seen_q      <= 1'b1;
			gate_ref_q  <= gate;
			tog_q       <= win_close ? '0 : tog_inc;
			prev_time_q <= time_q;
			cnt_high_q  <= add_high ? cnt_high_base + COUNT_BITS'(1) : cnt_high_base;
			cnt_low_q   <= add_low ? cnt_low_base + COUNT_BITS'(1) : cnt_low_base;
		end
	end

	// channel lanes
	assign lane_ctl.en       = done_fire;
	assign lane_ctl.clear    = win_close;
	assign lane_ctl.add_high = add_high;
	assign lane_ctl.add_low  = add_low;

	gwsa_lane u_lane0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.word     (ch0_word_q),
		.high_sum (l0_high),
		.low_sum  (l0_low)
	);

	gwsa_lane u_lane1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lane_ctl),
		.word     (ch1_word_q),
		.high_sum (l1_high),
		.low_sum  (l1_low)
	);

	// merge stage: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			sample_time_q <= time_q;
			gap_flag_q    <= gap;
			gap_ticks_q   <= gap ? diff : '0;
			window_done_q <= win_close;
			ch0_high_q    <= win_close ? l0_high : '0;
			ch0_low_q     <= win_close ? l0_low : '0;
			ch1_high_q    <= win_close ? l1_high : '0;
			ch1_low_q     <= win_close ? l1_low : '0;
			high_count_q  <= win_close ? CNT_OUT_W'(cnt_high_q) : '0;
			low_count_q   <= win_close ? CNT_OUT_W'(cnt_low_q) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_time  = sample_time_q;
	assign gap_flag     = gap_flag_q;
	assign gap_ticks    = gap_ticks_q;
	assign window_done  = window_done_q;
	assign ch0_high_sum = $signed(ch0_high_q);
	assign ch0_low_sum  = $signed(ch0_low_q);
	assign ch1_high_sum = $signed(ch1_high_q);
	assign ch1_low_sum  = $signed(ch1_low_q);
	assign high_count   = high_count_q;
	assign low_count    = low_count_q;

`ifndef SYNTHESIS
	// one item in flight: no new item right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |=> !in_ready)
		else $error("item accepted while another is in work");

	// a finished item holds while the output register is occupied
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("finished item dropped while output stalled");

	// no window sums or counts unless a window closed
	a_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_done) |->
		(high_count == '0 && low_count == '0 && ch0_high_sum == '0 &&
		ch0_low_sum == '0 && ch1_high_sum == '0 && ch1_low_sum == '0))
		else $error("window fields set without a closed window");

	// gap ticks only with a gap
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !gap_flag) |-> (gap_ticks == '0))
		else $error("gap ticks set without a gap");

	// toggle counter never rests at the window-closing value
	a_tog_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (tog_q != TOG_CLOSE))
		else $error("toggle count left at close value");
`endif

endmodule

`default_nettype wire
